@@ hw/rtl/sha256c_pkg.sv @@
// Shared types, round constants and mixing functions for the SHA-256 compression pipeline.
`timescale 1ns / 1ps

package sha256c_pkg;

  localparam int NUM_ROUNDS = 64;
  localparam int CHAIN_WORDS = 8;
  localparam int SCHED_WORDS = 16;

  typedef logic [31:0] word_t;

  // One word in flight: working variables a..h, the chaining value to add back at the
  // end, and a sliding window of sixteen schedule words starting at the current round.
  typedef struct packed {
    word_t [CHAIN_WORDS-1:0] state;
    word_t [CHAIN_WORDS-1:0] chain;
    word_t [SCHED_WORDS-1:0] sched;
  } sha_item_t;

  localparam word_t ROUND_CONST [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ hw/rtl/sha256_compression.sv @@
// Top level: a row of 64 round cells followed by the feed-forward add and output register.
// Throughput: one word accepted per cycle, sustained, as long as results are taken.
// A word passes through the 64 round cells, one per round, and then the output register;
// stalls on the output hold its result back further.
// Each cell holds its word until the next stage frees, so bubbles close up under a stall.
// Reset (synchronous) empties every stage; words in flight at reset are dropped.
`timescale 1ns / 1ps

module sha256_compression (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [63:0] chain_w0_w1,
  input  logic [63:0] chain_w2_w3,
  input  logic [63:0] chain_w4_w5,
  input  logic [63:0] chain_w6_w7,
  input  logic [63:0] block_w0_w1,
  input  logic [63:0] block_w2_w3,
  input  logic [63:0] block_w4_w5,
  input  logic [63:0] block_w6_w7,
  input  logic [63:0] block_w8_w9,
  input  logic [63:0] block_w10_w11,
  input  logic [63:0] block_w12_w13,
  input  logic [63:0] block_w14_w15,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [63:0] digest_w0_w1,
  output logic [63:0] digest_w2_w3,
  output logic [63:0] digest_w4_w5,
  output logic [63:0] digest_w6_w7
);

  localparam int NR = sha256c_pkg::NUM_ROUNDS;

  sha256c_pkg::sha_item_t stage_item  [NR+1];
  logic                   stage_valid [NR+1];
  logic                   stage_ready [NR+1];

  always_comb begin
    stage_item[0].state = {chain_w6_w7[31:0], chain_w6_w7[63:32],
                           chain_w4_w5[31:0], chain_w4_w5[63:32],
                           chain_w2_w3[31:0], chain_w2_w3[63:32],
                           chain_w0_w1[31:0], chain_w0_w1[63:32]};
    stage_item[0].chain = stage_item[0].state;
    stage_item[0].sched = {block_w14_w15[31:0], block_w14_w15[63:32],
                           block_w12_w13[31:0], block_w12_w13[63:32],
                           block_w10_w11[31:0], block_w10_w11[63:32],
                           block_w8_w9[31:0],   block_w8_w9[63:32],
                           block_w6_w7[31:0],   block_w6_w7[63:32],
                           block_w4_w5[31:0],   block_w4_w5[63:32],
                           block_w2_w3[31:0],   block_w2_w3[63:32],
                           block_w0_w1[31:0],   block_w0_w1[63:32]};
  end

  assign stage_valid[0] = req_valid;
  assign req_stall      = !stage_ready[0];

  for (genvar r = 0; r < NR; r++) begin : g_round
    sha256c_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .rc        (sha256c_pkg::ROUND_CONST[r]),
      .in_valid  (stage_valid[r]),
      .in_item   (stage_item[r]),
      .in_ready  (stage_ready[r]),
      .out_valid (stage_valid[r+1]),
      .out_item  (stage_item[r+1]),
      .out_ready (stage_ready[r+1])
    );
  end

  sha256c_final u_final (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (stage_valid[NR]),
    .in_item      (stage_item[NR]),
    .in_ready     (stage_ready[NR]),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .digest_w0_w1 (digest_w0_w1),
    .digest_w2_w3 (digest_w2_w3),
    .digest_w4_w5 (digest_w4_w5),
    .digest_w6_w7 (digest_w6_w7)
  );

endmodule

@@ hw/rtl/sha256c_round_cell.sv @@
// One compression round plus one schedule expansion step, with its own pipeline register.
`timescale 1ns / 1ps

module sha256c_round_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256c_pkg::word_t     rc,
  input  logic                   in_valid,
  input  sha256c_pkg::sha_item_t in_item,
  output logic                   in_ready,
  output logic                   out_valid,
  output sha256c_pkg::sha_item_t out_item,
  input  logic                   out_ready
);

  logic                   valid;
  sha256c_pkg::sha_item_t item;
  sha256c_pkg::sha_item_t item_next;
  sha256c_pkg::word_t     t1;
  sha256c_pkg::word_t     t2;
  sha256c_pkg::word_t     choose;
  sha256c_pkg::word_t     major;
  sha256c_pkg::word_t     sched_new;

  // The stage takes a new word when it is empty or its word moves on this cycle.
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_comb begin
    choose = (in_item.state[4] & in_item.state[5]) ^ (~in_item.state[4] & in_item.state[6]);
    major  = (in_item.state[0] & in_item.state[1]) ^ (in_item.state[0] & in_item.state[2])
           ^ (in_item.state[1] & in_item.state[2]);
    t1 = in_item.state[7] + sha256c_pkg::big_sigma1(in_item.state[4]) + choose + rc
       + in_item.sched[0];
    t2 = sha256c_pkg::big_sigma0(in_item.state[0]) + major;
    sched_new = in_item.sched[0] + sha256c_pkg::small_sigma0(in_item.sched[1])
              + in_item.sched[9] + sha256c_pkg::small_sigma1(in_item.sched[14]);

    item_next.chain    = in_item.chain;
    item_next.state[7] = in_item.state[6];
    item_next.state[6] = in_item.state[5];
    item_next.state[5] = in_item.state[4];
    item_next.state[4] = in_item.state[3] + t1;
    item_next.state[3] = in_item.state[2];
    item_next.state[2] = in_item.state[1];
    item_next.state[1] = in_item.state[0];
    item_next.state[0] = t1 + t2;
    // The window slides by one word; the newly expanded word enters at the far end.
    for (int k = 0; k < sha256c_pkg::SCHED_WORDS - 1; k++) begin
      item_next.sched[k] = in_item.sched[k+1];
    end
    item_next.sched[sha256c_pkg::SCHED_WORDS-1] = sched_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

@@ hw/rtl/sha256c_final.sv @@
// Feed-forward addition of the chaining value and the output register.
`timescale 1ns / 1ps

module sha256c_final (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  sha256c_pkg::sha_item_t in_item,
  output logic                   in_ready,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [63:0]            digest_w0_w1,
  output logic [63:0]            digest_w2_w3,
  output logic [63:0]            digest_w4_w5,
  output logic [63:0]            digest_w6_w7
);

  logic                                             valid;
  sha256c_pkg::word_t [sha256c_pkg::CHAIN_WORDS-1:0] sum;
  sha256c_pkg::word_t [sha256c_pkg::CHAIN_WORDS-1:0] digest;

  assign in_ready  = !valid || !rsp_stall;
  assign rsp_valid = valid;

  always_comb begin
    for (int k = 0; k < sha256c_pkg::CHAIN_WORDS; k++) begin
      sum[k] = in_item.state[k] + in_item.chain[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      digest <= sum;
    end
  end

  assign digest_w0_w1 = {digest[0], digest[1]};
  assign digest_w2_w3 = {digest[2], digest[3]};
  assign digest_w4_w5 = {digest[4], digest[5]};
  assign digest_w6_w7 = {digest[6], digest[7]};

endmodule

@@ hw/rtl/sha256c_checker.sv @@
// Port-level checks for the compression pipeline, bound to the top level.
`timescale 1ns / 1ps

module sha256c_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [63:0] digest_w0_w1,
  input logic [63:0] digest_w2_w3,
  input logic [63:0] digest_w4_w5,
  input logic [63:0] digest_w6_w7
);

  // Reset empties the pipeline: no result right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown right after reset");

  // An empty pipeline never pushes back on the request side.
  a_reset_ready: assert property (@(posedge clk) rst |=> !req_stall)
    else $error("request stalled right after reset");

  // Back pressure reaches the input only when the output holds a result that waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled without a waiting result");

  // A waiting result stays and holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(digest_w0_w1)
      && $stable(digest_w2_w3) && $stable(digest_w4_w5) && $stable(digest_w6_w7)))
    else $error("waiting result dropped or changed");

endmodule

bind sha256_compression sha256c_checker u_sha256c_checker (
  .clk          (clk),
  .rst          (rst),
  .req_stall    (req_stall),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .digest_w0_w1 (digest_w0_w1),
  .digest_w2_w3 (digest_w2_w3),
  .digest_w4_w5 (digest_w4_w5),
  .digest_w6_w7 (digest_w6_w7)
);
